@@ sv/ihu_pkg.sv @@
// Shared constants, types and helpers for the inverse hyperbolic unit.
`timescale 1ns / 1ps

package ihu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int LOG_FRAC  = 48;
    localparam int LOG_ITERS = LOG_FRAC;
    localparam int SQ_W      = 2 * WORD_BITS;
    localparam int ROOT_W    = 64;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int T_W       = ROOT_W + 1;
    localparam int EXP_W     = 7;
    localparam int L2_W      = 64;
    localparam int NUM_W     = FRAC_BITS + 1;
    localparam int ROUND_SH  = LOG_FRAC - FRAC_BITS;
    localparam int LOG_LANES = 2;

    localparam logic [WORD_BITS-1:0] FX_ONE    = WORD_BITS'(1) << FRAC_BITS;
    localparam logic [SQ_W-1:0]      FX_ONE_SQ = SQ_W'(1) << (2 * FRAC_BITS);
    localparam logic [63:0]          LN2_Q64   = 64'hB17217F7D1CF79AC;

    typedef enum logic [1:0] {
        FN_ASINH = 2'd0,
        FN_ACOSH = 2'd1,
        FN_ATANH = 2'd2
    } fn_t;

    // number of significant bits
    function automatic logic [EXP_W-1:0] bit_len(input logic [T_W-1:0] v);
        logic [EXP_W-1:0] n;
        n = '0;
        for (int i = 0; i < T_W; i++) begin
            if (v[i])
            begin
                n = EXP_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

@@ sv/ihu_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module ihu_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ihu_pkg::RAD_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [ihu_pkg::ROOT_W-1:0]  out_root,
    output logic [SIDE_W-1:0]           out_side
);

    localparam int STAGES = ihu_pkg::ROOT_W;
    localparam int REM_W  = ihu_pkg::ROOT_W + 2;
    localparam int RAD_W  = ihu_pkg::RAD_W;
    localparam int ROOT_W = ihu_pkg::ROOT_W;

    logic              valid_reg [0:STAGES-1];
    logic [ROOT_W-1:0] root_reg  [0:STAGES-1];
    logic [SIDE_W-1:0] side_reg  [0:STAGES-1];
    logic [REM_W-1:0]  rem_reg   [0:STAGES-2];
    logic [RAD_W-1:0]  rad_reg   [0:STAGES-2];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic              vin;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [SIDE_W-1:0] side_in;
        logic [REM_W-1:0]  shifted;
        logic [REM_W-1:0]  trial;
        logic              take;

        if (k == 0) begin : g_first
            assign vin     = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end else begin : g_next
            assign vin     = valid_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign shifted = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
        assign trial   = {root_in, 2'b01};
        assign take    = (shifted >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[k] <= {root_in[ROOT_W-2:0], take};
                side_reg[k] <= side_in;
            end
        end

        if (k < STAGES - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (shifted - trial) : shifted;
                    rad_reg[k] <= {rad_in[RAD_W-3:0], 2'b00};
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_root  = root_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

@@ sv/ihu_log2.sv @@
// Pipelined log2 by repeated squaring, two lanes, one fraction bit per two stages.
`timescale 1ns / 1ps

module ihu_log2 #(
    parameter int SIDE_W = 1
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic                                               en,
    input  logic                                               in_valid,
    input  logic [ihu_pkg::LOG_LANES-1:0][ihu_pkg::T_W-1:0]    in_v,
    input  logic [SIDE_W-1:0]                                  in_side,
    output logic                                               out_valid,
    output logic [ihu_pkg::LOG_LANES-1:0][ihu_pkg::L2_W-1:0]   out_l2,
    output logic [SIDE_W-1:0]                                  out_side
);

    localparam int ITERS = ihu_pkg::LOG_ITERS;
    localparam int NS    = 2 + 2 * ITERS;
    localparam int T_W   = ihu_pkg::T_W;
    localparam int E_W   = ihu_pkg::EXP_W;
    localparam int LF    = ihu_pkg::LOG_FRAC;
    localparam int TOP_W = ihu_pkg::L2_W - E_W - LF;

    logic              valid_reg [0:NS-1];
    logic [SIDE_W-1:0] side_reg  [0:NS-1];

    for (genvar s = 0; s < NS; s++) begin : g_ctl
        logic              vin;
        logic [SIDE_W-1:0] sin;
        if (s == 0) begin : g_first
            assign vin = in_valid;
            assign sin = in_side;
        end else begin : g_next
            assign vin = valid_reg[s-1];
            assign sin = side_reg[s-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s] <= sin;
            end
        end
    end

    for (genvar l = 0; l < ihu_pkg::LOG_LANES; l++) begin : g_lane
        logic [T_W-1:0] v_reg;
        logic [E_W-1:0] ea_reg;
        logic [62:0]    mb_reg;
        logic [E_W-1:0] eb_reg;
        logic [T_W-1:0] shl;
        logic [T_W-1:0] shr;

        logic [61:0]    p11_reg [0:ITERS-1];
        logic [62:0]    p01_reg [0:ITERS-1];
        logic [63:0]    p00_reg [0:ITERS-1];
        logic [E_W-1:0] ep_reg  [0:ITERS-1];
        logic [LF-1:0]  fp_reg  [0:ITERS-1];
        logic [E_W-1:0] es_reg  [0:ITERS-1];
        logic [LF-1:0]  fs_reg  [0:ITERS-1];
        logic [62:0]    ms_reg  [0:ITERS-2];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg  <= in_v[l];
                ea_reg <= ihu_pkg::bit_len(in_v[l]) - E_W'(1);
            end
        end

        assign shl = v_reg << (E_W'(62) - ea_reg);
        assign shr = v_reg >> (ea_reg - E_W'(62));

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                mb_reg <= (ea_reg >= E_W'(62)) ? shr[62:0] : shl[62:0];
                eb_reg <= ea_reg;
            end
        end

        for (genvar i = 0; i < ITERS; i++) begin : g_iter
            logic [62:0]    m_in;
            logic [E_W-1:0] e_in;
            logic [LF-1:0]  f_in;
            logic [30:0]    a1;
            logic [31:0]    a0;
            logic [125:0]   psum;
            logic [63:0]    mn;

            if (i == 0) begin : g_first
                assign m_in = mb_reg;
                assign e_in = eb_reg;
                assign f_in = '0;
            end else begin : g_next
                assign m_in = ms_reg[i-1];
                assign e_in = es_reg[i-1];
                assign f_in = fs_reg[i-1];
            end

            assign a1 = m_in[62:32];
            assign a0 = m_in[31:0];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p11_reg[i] <= 62'(a1) * 62'(a1);
                    p01_reg[i] <= 63'(a1) * 63'(a0);
                    p00_reg[i] <= 64'(a0) * 64'(a0);
                    ep_reg[i]  <= e_in;
                    fp_reg[i]  <= f_in;
                end
            end

            assign psum = {p11_reg[i], 64'd0} + 126'({p01_reg[i], 33'd0})
                        + 126'(p00_reg[i]);
            assign mn   = psum[125:62];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    es_reg[i] <= ep_reg[i];
                    fs_reg[i] <= {fp_reg[i][LF-2:0], mn[63]};
                end
            end

            if (i < ITERS - 1) begin : g_m
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        ms_reg[i] <= mn[63] ? mn[63:1] : mn[62:0];
                    end
                end
            end
        end

        assign out_l2[l] = {TOP_W'(0), es_reg[ITERS-1], fs_reg[ITERS-1]};
    end

    assign out_valid = valid_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

@@ sv/inverse_hyperbolic_unit_top.sv @@
// Top level of the inverse hyperbolic unit: operand prep, root, log and rounding stages.
// One transaction in and one out per cycle when the result side keeps up. Each result
// passes through 4 prep stages, 64 square-root stages (one root bit each), 1 sum stage,
// 98 log2 stages (normalise, then one squaring per fraction bit over two stages) and 4
// finish stages for combining the logs, the ln2 product and rounding. A stall on the
// result side holds the whole pipeline; req_ready follows rsp_ready or an empty output
// register. No state is kept between transactions.
`timescale 1ns / 1ps

module inverse_hyperbolic_unit_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  logic [1:0]                            req_type,
    input  logic signed [ihu_pkg::WORD_BITS-1:0]  x_value,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output logic signed [ihu_pkg::WORD_BITS-1:0]  fn_result,
    output logic                                  domain_error
);

    localparam int W   = ihu_pkg::WORD_BITS;
    localparam int SQW = ihu_pkg::SQ_W;
    localparam int NW  = ihu_pkg::NUM_W;
    localparam int EW  = ihu_pkg::EXP_W;
    localparam int TW  = ihu_pkg::T_W;
    localparam int LW  = ihu_pkg::L2_W;
    localparam int LF  = ihu_pkg::LOG_FRAC;
    localparam int RS  = ihu_pkg::ROUND_SH;

    typedef struct packed {
        ihu_pkg::fn_t    fn;
        logic            neg;
        logic            dom;
        logic [W-1:0]    mag;
        logic [EW-1:0]   g;
        logic [NW-1:0]   num;
        logic [NW-1:0]   den;
    } sq_side_t;

    typedef struct packed {
        ihu_pkg::fn_t    fn;
        logic            neg;
        logic            dom;
        logic [EW-1:0]   g;
    } lg_side_t;

    logic en;

    // prep stages
    logic          v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    sq_side_t      s0_reg, s1_reg, s2_reg, s3_reg;
    sq_side_t      s1_next, s2_next;
    logic [SQW-1:0] sq1_reg;
    logic [SQW-1:0] rad2_reg;
    logic [ihu_pkg::RAD_W-1:0] rad3_reg;

    logic [W-1:0]   raw;
    logic [W-1:0]   mag_c;
    logic           neg_c;
    logic           dom_c;
    ihu_pkg::fn_t   fn_c;
    logic [SQW-1:0] sum2;
    logic [EW-1:0]  bl2;

    // root and log
    logic                           sq_valid;
    logic [ihu_pkg::ROOT_W-1:0]     sq_root;
    sq_side_t                       sq_side;
    logic [TW-1:0]                  t4;
    logic [ihu_pkg::LOG_LANES-1:0][TW-1:0] lv4_reg;
    lg_side_t                       lg4_reg;
    logic                           lg_valid;
    logic [ihu_pkg::LOG_LANES-1:0][LW-1:0] lg_l2;
    lg_side_t                       lg_side;

    // finish stages
    logic          vf0_reg, vf1_reg, vf2_reg, rsp_valid_reg;
    logic [LW-1:0] u_reg;
    logic          negf_reg, half_reg, domf0_reg;
    logic          negf1_reg, half1_reg, domf1_reg;
    logic          negf2_reg, half2_reg, domf2_reg;
    logic [63:0]   pp11_reg, pp10_reg, pp01_reg, pp00_reg;
    logic [63:0]   ln_reg;
    logic [W-1:0]  res_reg;
    logic          dom_out_reg;

    logic [LW-1:0] sub_f;
    logic [LW-1:0] diff_f;
    logic          negf_c;
    logic [127:0]  full_f;
    logic [64:0]   rnd_f;
    logic [W-1:0]  r_f;

    assign en        = rsp_ready || !rsp_valid_reg;
    assign req_ready = en;

    // stage 0: magnitude and domain
    assign raw   = $unsigned(x_value);
    assign neg_c = raw[W-1];
    assign mag_c = neg_c ? (~raw + W'(1)) : raw;
    assign fn_c  = ihu_pkg::fn_t'(req_type);

    always_comb
    begin
        case (fn_c)
            ihu_pkg::FN_ASINH: dom_c = 1'b0;
            ihu_pkg::FN_ACOSH: dom_c = neg_c || (mag_c < ihu_pkg::FX_ONE);
            ihu_pkg::FN_ATANH: dom_c = (mag_c >= ihu_pkg::FX_ONE);
            default:           dom_c = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= req_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_reg.fn  <= fn_c;
            s0_reg.neg <= neg_c;
            s0_reg.dom <= dom_c;
            s0_reg.mag <= mag_c;
            s0_reg.g   <= '0;
            s0_reg.num <= '0;
            s0_reg.den <= '0;
        end
    end

    // stage 1: square, atanh ratio terms
    always_comb
    begin
        s1_next = s0_reg;
        if (s0_reg.neg)
        begin
            s1_next.num = NW'(ihu_pkg::FX_ONE) - NW'(s0_reg.mag[NW-2:0]);
            s1_next.den = NW'(ihu_pkg::FX_ONE) + NW'(s0_reg.mag[NW-2:0]);
        end
        else
        begin
            s1_next.num = NW'(ihu_pkg::FX_ONE) + NW'(s0_reg.mag[NW-2:0]);
            s1_next.den = NW'(ihu_pkg::FX_ONE) - NW'(s0_reg.mag[NW-2:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq1_reg <= SQW'(s0_reg.mag) * SQW'(s0_reg.mag);
            s1_reg  <= s1_next;
        end
    end

    // stage 2: radicand and guard shift
    assign sum2 = sq1_reg + ihu_pkg::FX_ONE_SQ;
    assign bl2  = ihu_pkg::bit_len(TW'(sum2));

    always_comb
    begin
        s2_next   = s1_reg;
        s2_next.g = (EW'(127) - bl2) >> 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad2_reg <= (s1_reg.fn == ihu_pkg::FN_ACOSH) ? (sq1_reg - ihu_pkg::FX_ONE_SQ)
                                                         : sum2;
            s2_reg   <= s2_next;
        end
    end

    // stage 3: align radicand
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad3_reg <= ihu_pkg::RAD_W'(rad2_reg) << {s2_reg.g, 1'b0};
            s3_reg   <= s2_reg;
        end
    end

    ihu_sqrt #(
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (rad3_reg),
        .in_side   (s3_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage 4: a*2^g + root, pick log operands
    assign t4 = (TW'(sq_side.mag) << sq_side.g) + TW'(sq_root);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lv4_reg[0]  <= (sq_side.fn == ihu_pkg::FN_ATANH) ? TW'(sq_side.num) : t4;
            lv4_reg[1]  <= TW'(sq_side.den);
            lg4_reg.fn  <= sq_side.fn;
            lg4_reg.neg <= sq_side.neg;
            lg4_reg.dom <= sq_side.dom;
            lg4_reg.g   <= sq_side.g;
        end
    end

    ihu_log2 #(
        .SIDE_W ($bits(lg_side_t))
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_v      (lv4_reg),
        .in_side   (lg4_reg),
        .out_valid (lg_valid),
        .out_l2    (lg_l2),
        .out_side  (lg_side)
    );

    // finish 0: combine logs, take magnitude
    assign sub_f  = (lg_side.fn == ihu_pkg::FN_ATANH)
                  ? lg_l2[1]
                  : {(LW - EW - LF)'(0), EW'(lg_side.g + EW'(ihu_pkg::FRAC_BITS)), LF'(0)};
    assign diff_f = lg_l2[0] - sub_f;
    assign negf_c = (lg_side.fn == ihu_pkg::FN_ASINH) ? lg_side.neg : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf0_reg       <= 1'b0;
            vf1_reg       <= 1'b0;
            vf2_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vf0_reg       <= lg_valid;
            vf1_reg       <= vf0_reg;
            vf2_reg       <= vf1_reg;
            rsp_valid_reg <= vf2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg     <= diff_f[LW-1] ? (~diff_f + LW'(1)) : diff_f;
            negf_reg  <= negf_c ^ diff_f[LW-1];
            half_reg  <= (lg_side.fn == ihu_pkg::FN_ATANH);
            domf0_reg <= lg_side.dom;
        end
    end

    // finish 1: partial products with ln2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp11_reg  <= 64'(u_reg[63:32]) * 64'(ihu_pkg::LN2_Q64[63:32]);
            pp10_reg  <= 64'(u_reg[63:32]) * 64'(ihu_pkg::LN2_Q64[31:0]);
            pp01_reg  <= 64'(u_reg[31:0]) * 64'(ihu_pkg::LN2_Q64[63:32]);
            pp00_reg  <= 64'(u_reg[31:0]) * 64'(ihu_pkg::LN2_Q64[31:0]);
            negf1_reg <= negf_reg;
            half1_reg <= half_reg;
            domf1_reg <= domf0_reg;
        end
    end

    // finish 2: sum partial products
    assign full_f = {pp11_reg, 64'd0} + 128'({pp10_reg, 32'd0})
                  + 128'({pp01_reg, 32'd0}) + 128'(pp00_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ln_reg    <= full_f[127:64];
            negf2_reg <= negf1_reg;
            half2_reg <= half1_reg;
            domf2_reg <= domf1_reg;
        end
    end

    // finish 3: round, sign, output register
    assign rnd_f = half2_reg ? ((65'(ln_reg) + (65'(1) << RS)) >> (RS + 1))
                             : ((65'(ln_reg) + (65'(1) << (RS - 1))) >> RS);
    assign r_f   = negf2_reg ? (~rnd_f[W-1:0] + W'(1)) : rnd_f[W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg     <= domf2_reg ? '0 : r_f;
            dom_out_reg <= domf2_reg;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign fn_result    = $signed(res_reg);
    assign domain_error = dom_out_reg;

endmodule

@@ sv/ihu_checker.sv @@
// Port-level assertions for the inverse hyperbolic unit, bound to the top level.
`timescale 1ns / 1ps

module ihu_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  req_valid,
    input logic                                  req_ready,
    input logic [1:0]                            req_type,
    input logic signed [ihu_pkg::WORD_BITS-1:0]  x_value,
    input logic                                  rsp_valid,
    input logic                                  rsp_ready,
    input logic signed [ihu_pkg::WORD_BITS-1:0]  fn_result,
    input logic                                  domain_error
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result transaction dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(fn_result) && $stable(domain_error))
        else $error("result payload changed while stalled");

    a_dom_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && domain_error |-> fn_result == '0)
        else $error("domain error with non-zero result");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready == (rsp_ready || !rsp_valid))
        else $error("req_ready does not follow result side");

endmodule

bind inverse_hyperbolic_unit_top ihu_checker u_ihu_checker (.*);

@@ test/tb_top.sv @@
// Testbench for inverse_hyperbolic_unit_top: queue-fed driver, bit-exact predictor, result monitor.
`timescale 1ns / 1ps

module tb_top;

    localparam int RSP_HOLD     = 400;
    localparam int HOLD_AT      = 300;
    localparam int CALM_LO      = 1000;
    localparam int CALM_HI      = 1300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 250;
    localparam int N_RANDOM     = 2000;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] x;
    } op_item_t;

    typedef struct {
        logic [31:0] res;
        logic        dom;
    } fn_value_t;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_ready;
    logic [1:0]  req_type;
    logic signed [ihu_pkg::WORD_BITS-1:0] x_value;
    logic        rsp_valid;
    logic        rsp_ready;
    logic signed [ihu_pkg::WORD_BITS-1:0] fn_result;
    logic        domain_error;

    op_item_t  pending_ops[$];
    fn_value_t awaited_vals[$];
    logic      req_fire;
    int        sent_cnt;
    int        got_cnt;
    int        mismatch_cnt;
    int        stall_cnt;
    int        hold_cnt;
    bit        hold_done;
    bit        stim_done;

    inverse_hyperbolic_unit_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .x_value      (x_value),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .fn_result    (fn_result),
        .domain_error (domain_error)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int len128(input logic [127:0] v);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] ihu_log2(input logic [127:0] v);
        int           e;
        logic [63:0]  m;
        logic [63:0]  frac;
        logic [127:0] p;
        e = len128(v) - 1;
        frac = '0;
        if (e >= 62)
        begin
            p = v >> (e - 62);
            m = p[63:0];
        end
        else
        begin
            m = v[63:0] << (62 - e);
        end
        for (int i = 0; i < ihu_pkg::LOG_FRAC; i++)
        begin
            p = {64'd0, m} * {64'd0, m};
            m = p[125:62];
            frac = frac << 1;
            if (m[63])
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(e) << ihu_pkg::LOG_FRAC) + frac;
    endfunction

    function automatic logic [63:0] ihu_isqrt(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (({64'd0, t} * {64'd0, t}) <= v)
            begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] ihu_root_log(input logic [63:0] mag, input bit plus);
        logic [127:0] sq;
        logic [127:0] w2;
        logic [127:0] sum;
        logic [127:0] rad;
        logic [127:0] t;
        logic [63:0]  s;
        int           g;
        sq = {64'd0, mag} * {64'd0, mag};
        w2 = 128'd1 << (2 * ihu_pkg::FRAC_BITS);
        sum = sq + w2;
        g = (127 - len128(sum)) / 2;
        rad = plus ? sum : sq - w2;
        s = ihu_isqrt(rad << (2 * g));
        t = ({64'd0, mag} << g) + {64'd0, s};
        return ihu_log2(t) - (64'(g + ihu_pkg::FRAC_BITS) << ihu_pkg::LOG_FRAC);
    endfunction

    function automatic logic [31:0] ihu_round_ln(input logic [63:0] l2, input bit negate,
                                                 input int half);
        logic [63:0]  u;
        logic [127:0] p;
        logic [63:0]  r;
        bit           neg;
        int           s;
        u = l2;
        neg = negate;
        s = ihu_pkg::LOG_FRAC - ihu_pkg::FRAC_BITS + half;
        if (l2[63])
        begin
            u = -u;
            neg = !neg;
        end
        p = {64'd0, u} * {64'd0, ihu_pkg::LN2_Q64};
        r = (p[127:64] + (64'd1 << (s - 1))) >> s;
        if (neg)
        begin
            r = -r;
        end
        return r[31:0];
    endfunction

    function automatic fn_value_t predict_fn(input logic [1:0] op, input logic [31:0] x);
        fn_value_t   o;
        bit          neg;
        logic [63:0] mag;
        logic [63:0] w;
        logic [63:0] num;
        logic [63:0] den;
        o.res = '0;
        o.dom = 1'b0;
        neg = x[31];
        mag = {32'd0, neg ? -x : x};
        w = 64'd1 << ihu_pkg::FRAC_BITS;
        case (op)
            ihu_pkg::FN_ASINH:
            begin
                o.res = ihu_round_ln(ihu_root_log(mag, 1'b1), neg, 0);
            end
            ihu_pkg::FN_ACOSH:
            begin
                if (neg || mag < w)
                begin
                    o.dom = 1'b1;
                end
                else
                begin
                    o.res = ihu_round_ln(ihu_root_log(mag, 1'b0), 1'b0, 0);
                end
            end
            ihu_pkg::FN_ATANH:
            begin
                if (mag >= w)
                begin
                    o.dom = 1'b1;
                end
                else
                begin
                    num = neg ? w - mag : w + mag;
                    den = neg ? w + mag : w - mag;
                    o.res = ihu_round_ln(ihu_log2({64'd0, num}) - ihu_log2({64'd0, den}),
                                         1'b0, 1);
                end
            end
            default:
            begin
                o.dom = 1'b1;
            end
        endcase
        return o;
    endfunction

    function automatic bit calm_phase(input int n);
        return n >= CALM_LO && n < CALM_HI;
    endfunction

    // driver
    always @(negedge clk)
    begin
        op_item_t it;
        if (rst_n && (!req_valid || req_fire))
        begin
            if (pending_ops.size() == 0 || (!calm_phase(sent_cnt) && $urandom_range(99) < 33))
            begin
                req_valid <= 1'b0;
            end
            else
            begin
                it = pending_ops.pop_front();
                req_valid <= 1'b1;
                req_type  <= it.op;
                x_value   <= it.x;
            end
        end
    end

    // receiver, with one long hold-off to back the pipeline up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!hold_done && hold_cnt == 0 && sent_cnt >= HOLD_AT)
            begin
                hold_cnt <= RSP_HOLD;
                rsp_ready <= 1'b0;
            end
            else if (hold_cnt > 1)
            begin
                hold_cnt <= hold_cnt - 1;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (hold_cnt == 1)
                begin
                    hold_done <= 1'b1;
                    hold_cnt <= 0;
                end
                rsp_ready <= calm_phase(sent_cnt) || $urandom_range(99) >= 33;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        fn_value_t ex;
        req_fire <= req_valid && req_ready;
        if (req_valid && req_ready)
        begin
            awaited_vals.push_back(predict_fn(req_type, x_value));
            sent_cnt <= sent_cnt + 1;
        end
        if (rsp_valid && rsp_ready)
        begin
            got_cnt <= got_cnt + 1;
            if (awaited_vals.size() == 0)
            begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected transaction: res %h dom %b", fn_result, domain_error);
            end
            else
            begin
                ex = awaited_vals.pop_front();
                if (ex.res !== fn_result || ex.dom !== domain_error)
                begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("mismatch: exp res %h dom %b, got res %h dom %b",
                                 ex.res, ex.dom, fn_result, domain_error);
                end
            end
        end
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            stall_cnt <= 0;
        end
        else if (rst_n)
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("tb_top NOT OK");
                $finish;
            end
        end
    end

    task automatic add_op(input logic [1:0] op, input logic [31:0] x);
        op_item_t it;
        it.op = op;
        it.x = x;
        pending_ops.push_back(it);
    endtask

    function automatic logic [31:0] rand_x();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072))) - 32'sd65536;
            2: return 32'($signed($urandom_range(2097152))) - 32'sd1048576;
            default: return $urandom & 32'h8000FFFF;
        endcase
    endfunction

    initial
    begin
        logic [1:0] op;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_type = ihu_pkg::FN_ASINH;
        x_value = '0;
        rsp_ready = 1'b0;
        req_fire = 1'b0;
        sent_cnt = 0;
        got_cnt = 0;
        mismatch_cnt = 0;
        stall_cnt = 0;
        hold_cnt = 0;
        hold_done = 1'b0;
        stim_done = 1'b0;

        add_op(ihu_pkg::FN_ASINH, 32'h0000_0000);
        add_op(ihu_pkg::FN_ASINH, 32'h7FFF_FFFF);
        add_op(ihu_pkg::FN_ASINH, 32'h8000_0000);
        add_op(ihu_pkg::FN_ASINH, 32'h0001_0000);
        add_op(ihu_pkg::FN_ASINH, 32'hFFFF_0000);
        add_op(ihu_pkg::FN_ASINH, 32'h0000_0001);
        add_op(ihu_pkg::FN_ACOSH, 32'h0001_0000);
        add_op(ihu_pkg::FN_ACOSH, 32'h0000_FFFF);
        add_op(ihu_pkg::FN_ACOSH, 32'h0001_0001);
        add_op(ihu_pkg::FN_ACOSH, 32'h7FFF_FFFF);
        add_op(ihu_pkg::FN_ACOSH, 32'h8000_0000);
        add_op(ihu_pkg::FN_ACOSH, 32'h0000_0000);
        add_op(ihu_pkg::FN_ATANH, 32'h0000_0000);
        add_op(ihu_pkg::FN_ATANH, 32'h0000_FFFF);
        add_op(ihu_pkg::FN_ATANH, 32'hFFFF_0001);
        add_op(ihu_pkg::FN_ATANH, 32'h0001_0000);
        add_op(ihu_pkg::FN_ATANH, 32'hFFFF_0000);
        add_op(ihu_pkg::FN_ATANH, 32'h7FFF_FFFF);
        add_op(ihu_pkg::FN_ATANH, 32'h8000_0000);
        add_op(ihu_pkg::FN_ATANH, 32'h0000_0001);
        add_op(FN_UNUSED, 32'h0000_0000);
        add_op(FN_UNUSED, 32'hFFFF_FFFF);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            op = ($urandom_range(19) == 0) ? FN_UNUSED : 2'($urandom_range(2));
            add_op(op, rand_x());
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait (pending_ops.size() == 0 && !req_valid);
        wait (awaited_vals.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && awaited_vals.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ihu_pkg.sv
sv/ihu_sqrt.sv
sv/ihu_log2.sv
sv/inverse_hyperbolic_unit_top.sv
sv/ihu_checker.sv
test/tb_top.sv
